### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Field widths, item kinds, character codes and register indexes shared by
// the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	localparam int unsigned KIND_W = 2;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ATTR_W = 8;
	localparam int unsigned COL_W  = 7;
	localparam int unsigned ROW_W  = 6;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUT    = 2'd0,
		KIND_SETPOS = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEXT_ATTR   = 2'd0,
		REG_CURSOR_ATTR = 2'd1,
		REG_CURSOR_ON   = 2'd2
	} cfg_reg_t;

	localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST   = 8'h07;
	localparam logic [ATTR_W-1:0] CURSOR_ATTR_RST = 8'h70;

endpackage

`default_nettype wire

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered. Contents are undefined after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = 4000,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console writer: a screen of character and attribute cells held in two
// RAMs, a cursor that is drawn by writing the cursor attribute under it, and
// put-char, set-position, clear and read-cell transactions.
//
// Steps: execute (unmark and character write, or the read address), then
// mark (cursor redraw) or, for read-cell, read data, then done, where the
// result register loads once the previous result has gone. NUL and
// backspace at the first cell go from execute straight to done. A
// transaction is accepted only in idle, so the next waits for that load.
// Scroll and clear add a sweep of every cell through the RAM ports, one cell
// a cycle, and a flush step between execute and mark.
// Reset clears the cursor to the first cell and loads the register defaults;
// the screen RAM is not cleared and holds garbage until a clear is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int unsigned SCREEN_ROWS = 50,
	parameter int unsigned SCREEN_COLS = 80
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// configuration write port
	input  wire logic                   cfg_wr_en,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

	// input stream
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [23:0]            s_axis_tdata,  // char_code[7:0], col[14:8], row[20:15]
	input  wire logic [KIND_W-1:0]      s_axis_tuser,  // kind[1:0]

	// result stream
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [31:0]                 m_axis_tdata   // cursor_col[6:0], cursor_row[12:7],
	                                                   // cell_char[20:13], cell_attr[28:21]
);

	// ------------------------------------------------------------------------
	// Geometry
	// ------------------------------------------------------------------------
	localparam int unsigned CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int unsigned AW    = $clog2(CELLS);

	localparam logic [AW-1:0]    CELL_LAST  = AW'(CELLS - 1);
	// first cell of the last row: sweep destinations from here on are blanked
	localparam logic [AW-1:0]    COPY_END   = AW'(CELLS - SCREEN_COLS);
	localparam logic [AW-1:0]    COLS_A     = AW'(SCREEN_COLS);
	localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(SCREEN_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST   = COL_W'(SCREEN_COLS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_FLUSH,
		ST_MARK,
		ST_RDATA,
		ST_DONE
	} state_t;

	// ------------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------------
	state_t             state_q;

	logic [ATTR_W-1:0]  text_attr_q;
	logic [ATTR_W-1:0]  cursor_attr_q;
	logic               cursor_on_q;

	// cursor held as row/column and as a cell address
	logic [ROW_W-1:0]   cur_row_q;
	logic [COL_W-1:0]   cur_col_q;
	logic [AW-1:0]      cur_idx_q;

	// transaction being worked on; position already saturated
	kind_t              item_kind_q;
	logic [CHAR_W-1:0]  item_char_q;
	logic [COL_W-1:0]   item_col_q;
	logic [ROW_W-1:0]   item_row_q;

	logic               bs_q;           // backspace: blank the character at the mark step
	logic               sweep_clear_q;  // sweep blanks every cell (clear) instead of scrolling
	logic [AW-1:0]      sweep_q;        // sweep destination address

	// sweep write stage: lines up with the registered RAM read data
	logic               sw_vld_s1;
	logic [AW-1:0]      sw_addr_s1;
	logic               sw_blank_s1;

	logic [CHAR_W-1:0]  rd_char_q;
	logic [ATTR_W-1:0]  rd_attr_q;

	logic               out_vld_q;
	logic [31:0]        out_data_q;

	// ------------------------------------------------------------------------
	// Input unpacking and saturation of the position
	// ------------------------------------------------------------------------
	logic [CHAR_W-1:0]  in_char;
	logic [COL_W-1:0]   in_col;
	logic [ROW_W-1:0]   in_row;
	logic [COL_W-1:0]   in_col_sat;
	logic [ROW_W-1:0]   in_row_sat;
	logic               in_accept;

	assign in_char    = s_axis_tdata[7:0];
	assign in_col     = s_axis_tdata[14:8];
	assign in_row     = s_axis_tdata[20:15];
	assign in_col_sat = (in_col > COL_LAST) ? COL_LAST : in_col;
	assign in_row_sat = (in_row > ROW_LAST) ? ROW_LAST : in_row;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// load the result register once the previous result has gone
	logic               out_load;

	assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

	// ------------------------------------------------------------------------
	// Decode of the held transaction (used in ST_EXEC)
	// ------------------------------------------------------------------------
	logic               is_put;
	logic               ch_nul;
	logic               ch_nl;
	logic               ch_bs;
	logic               ch_print;
	logic               at_first;
	logic               at_last_row;
	logic               at_last_col;
	logic               unmark_exec;
	logic               need_sweep;
	logic               done_direct;
	logic [ROW_W-1:0]   next_row;
	logic [COL_W-1:0]   next_col;
	logic [AW-1:0]      next_idx;
	logic [AW-1:0]      item_idx;

	assign is_put      = (item_kind_q == KIND_PUT);
	assign ch_nul      = (item_char_q == CH_NUL);
	assign ch_nl       = (item_char_q == CH_NEWLINE);
	assign ch_bs       = (item_char_q == CH_BACKSPACE);
	assign ch_print    = !ch_nul && !ch_nl && !ch_bs;
	assign at_first    = (cur_row_q == '0) && (cur_col_q == '0);
	assign at_last_row = (cur_row_q == ROW_LAST);
	assign at_last_col = (cur_col_q == COL_LAST);

	// drop the cursor attribute at the old position before a put or set-position move
	assign unmark_exec = (is_put && !ch_nul && !(ch_bs && at_first))
	                   || (item_kind_q == KIND_SETPOS);
	assign need_sweep  = (item_kind_q == KIND_CLEAR)
	                   || (is_put && ch_nl && at_last_row)
	                   || (is_put && ch_print && at_last_row && at_last_col);
	assign done_direct = is_put && (ch_nul || (ch_bs && at_first));

	always_comb begin
		next_row = cur_row_q;
		next_col = cur_col_q;
		case (item_kind_q)
			KIND_PUT: begin
				if (ch_nl) begin
					next_col = '0;
					next_row = at_last_row ? ROW_LAST : cur_row_q + ROW_W'(1);
				end else if (ch_bs) begin
					if (cur_col_q == '0) begin
						next_col = COL_LAST;
						next_row = cur_row_q - ROW_W'(1);
					end else begin
						next_col = cur_col_q - COL_W'(1);
					end
				end else if (at_last_col) begin
					next_col = '0;
					next_row = at_last_row ? ROW_LAST : cur_row_q + ROW_W'(1);
				end else begin
					next_col = cur_col_q + COL_W'(1);
				end
			end
			KIND_SETPOS: begin
				next_row = item_row_q;
				next_col = item_col_q;
			end
			KIND_CLEAR: begin
				next_row = '0;
				next_col = '0;
			end
			default: begin
				next_row = cur_row_q;
				next_col = cur_col_q;
			end
		endcase
	end

	assign next_idx = AW'(next_row) * COLS_A + AW'(next_col);
	assign item_idx = AW'(item_row_q) * COLS_A + AW'(item_col_q);

	// ------------------------------------------------------------------------
	// Screen RAMs: characters and attributes kept apart so that a character
	// or an attribute write needs no read-modify-write
	// ------------------------------------------------------------------------
	logic               ch_we;
	logic               at_we;
	logic [AW-1:0]      ram_waddr;
	logic [CHAR_W-1:0]  ch_wdata;
	logic [ATTR_W-1:0]  at_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [CHAR_W-1:0]  ch_rdata;
	logic [ATTR_W-1:0]  at_rdata;

	always_comb begin
		ch_we     = 1'b0;
		at_we     = 1'b0;
		ram_waddr = cur_idx_q;
		ch_wdata  = item_char_q;
		at_wdata  = text_attr_q;
		if (sw_vld_s1) begin
			// scroll copy (row below moves up) or blank fill
			ch_we     = 1'b1;
			at_we     = 1'b1;
			ram_waddr = sw_addr_s1;
			ch_wdata  = sw_blank_s1 ? CH_BLANK : ch_rdata;
			at_wdata  = sw_blank_s1 ? text_attr_q : at_rdata;
		end else begin
			case (state_q)
				ST_EXEC: begin
					at_we = unmark_exec;
					ch_we = is_put && ch_print;
				end
				ST_MARK: begin
					at_we    = cursor_on_q;
					at_wdata = cursor_attr_q;
					ch_we    = bs_q;
					ch_wdata = CH_BLANK;
				end
				default: begin
					ch_we = 1'b0;
					at_we = 1'b0;
				end
			endcase
		end
	end

	// read for the cell query, otherwise the sweep source one row down
	always_comb begin
		if (state_q == ST_EXEC) begin
			ram_raddr = item_idx;
		end else if (sweep_q < COPY_END) begin
			ram_raddr = sweep_q + COLS_A;
		end else begin
			ram_raddr = sweep_q;
		end
	end

	tcw_ram #(
		.DATA_W (CHAR_W),
		.DEPTH  (CELLS)
	) u_char_ram (
		.clk     (clk),
		.wr_en   (ch_we),
		.wr_addr (ram_waddr),
		.wr_data (ch_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ch_rdata)
	);

	tcw_ram #(
		.DATA_W (ATTR_W),
		.DEPTH  (CELLS)
	) u_attr_ram (
		.clk     (clk),
		.wr_en   (at_we),
		.wr_addr (ram_waddr),
		.wr_data (at_wdata),
		.rd_addr (ram_raddr),
		.rd_data (at_rdata)
	);

	// ------------------------------------------------------------------------
	// Sequencer, configuration and result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			text_attr_q   <= TEXT_ATTR_RST;
			cursor_attr_q <= CURSOR_ATTR_RST;
			cursor_on_q   <= 1'b1;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			cur_idx_q     <= '0;
			item_kind_q   <= KIND_PUT;
			item_char_q   <= '0;
			item_col_q    <= '0;
			item_row_q    <= '0;
			bs_q          <= 1'b0;
			sweep_clear_q <= 1'b0;
			sweep_q       <= '0;
			sw_vld_s1     <= 1'b0;
			sw_addr_s1    <= '0;
			sw_blank_s1   <= 1'b0;
			rd_char_q     <= '0;
			rd_attr_q     <= '0;
			out_vld_q     <= 1'b0;
			out_data_q    <= '0;
		end else begin
			// configuration: text attribute used at the next cell write, cursor settings at the next cursor redraw
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_TEXT_ATTR:   text_attr_q   <= cfg_wdata;
					REG_CURSOR_ATTR: cursor_attr_q <= cfg_wdata;
					REG_CURSOR_ON:   cursor_on_q   <= cfg_wdata[0];
					default: begin
						// index beyond the register list: drop the write
					end
				endcase
			end

			// result register: load a finished transaction, drop one taken downstream
			if (out_load) begin
				out_vld_q  <= 1'b1;
				out_data_q <= {3'b000, rd_attr_q, rd_char_q, cur_row_q, cur_col_q};
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			// sweep write comes in the cycle after its read
			sw_vld_s1 <= (state_q == ST_SWEEP);

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						item_kind_q <= kind_t'(s_axis_tuser);
						item_char_q <= in_char;
						item_col_q  <= in_col_sat;
						item_row_q  <= in_row_sat;
						state_q     <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					// unmark and character write happen this cycle on the RAMs
					rd_char_q     <= '0;
					rd_attr_q     <= '0;
					bs_q          <= is_put && ch_bs;
					sweep_clear_q <= (item_kind_q == KIND_CLEAR);
					sweep_q       <= '0;
					if (item_kind_q == KIND_READ) begin
						state_q <= ST_RDATA;
					end else if (done_direct) begin
						state_q <= ST_DONE;
					end else begin
						cur_row_q <= next_row;
						cur_col_q <= next_col;
						cur_idx_q <= next_idx;
						state_q   <= need_sweep ? ST_SWEEP : ST_MARK;
					end
				end

				ST_SWEEP: begin
					// one destination cell a cycle; the write follows in the next cycle
					sw_addr_s1  <= sweep_q;
					sw_blank_s1 <= sweep_clear_q || (sweep_q >= COPY_END);
					sweep_q     <= sweep_q + AW'(1);
					if (sweep_q == CELL_LAST) begin
						state_q <= ST_FLUSH;
					end
				end

				ST_FLUSH: begin
					// last sweep write retires this cycle
					state_q <= ST_MARK;
				end

				ST_MARK: begin
					state_q <= ST_DONE;
				end

				ST_RDATA: begin
					rd_char_q <= ch_rdata;
					rd_attr_q <= at_rdata;
					state_q   <= ST_DONE;
				end

				ST_DONE: begin
					// hold until the result register is free
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### test/tb_text_console_writer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_unit
// Self-checking bench for the text console writer. A mirror of the screen,
// cursor and attribute registers predicts the cursor position and read-back
// cell for every accepted transaction. The test tasks cover the edge cases,
// the register settings, output back-pressure and a long run of text-shaped
// random traffic. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_text_console_writer_unit;
	import tcw_pkg::*;

	localparam int unsigned SCREEN_ROWS = 50;
	localparam int unsigned SCREEN_COLS = 80;
	localparam int unsigned CELL_TOTAL  = SCREEN_ROWS * SCREEN_COLS;

	// Spare register slot: writes to it must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	localparam int unsigned RANDOM_ITEMS = 1100;
	// Scroll and clear each sweep the whole screen, so cap them
	localparam int unsigned SWEEP_BUDGET = 60;
	localparam int unsigned HOLD_CYCLES  = 500;
	// The longest item is one with a sweep; allow a margin after the last result
	localparam int unsigned DRAIN_SLACK  = 16;
	// Slowest run: ~1300 items with gaps and stalls plus 60 sweeps plus
	// hold-offs; taken several times over
	localparam int unsigned LIMIT_CYCLES = 2_000_000;

	// Result fields, cursor_col in the lowest bits
	typedef struct packed {
		logic [ATTR_W-1:0] attr;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_result_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_wr_en     = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [23:0]            s_axis_tdata  = '0;  // char_code[7:0], col[14:8], row[20:15]
	logic [KIND_W-1:0]      s_axis_tuser  = '0;  // kind[1:0]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [31:0]            m_axis_tdata;        // cursor_col[6:0], cursor_row[12:7],
	                                             // cell_char[20:13], cell_attr[28:21]

	text_console_writer_unit #(
		.SCREEN_ROWS(SCREEN_ROWS),
		.SCREEN_COLS(SCREEN_COLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Screen mirror: cells hold the character in [7:0] and the attribute
	// in [15:8]; the block has two separate RAMs that hold them
	// ------------------------------------------------------------------
	logic [15:0]       screen_mirror [CELL_TOTAL];
	int unsigned       cursor_pos    = 0;
	logic [ATTR_W-1:0] text_attr_m   = TEXT_ATTR_RST;
	logic [ATTR_W-1:0] cursor_attr_m = CURSOR_ATTR_RST;
	logic              cursor_on_m   = 1'b1;
	int unsigned       sweep_count   = 0;

	console_result_t   pending_results [$];
	int unsigned       fail_count    = 0;
	int unsigned       cycle_count   = 0;
	int unsigned       items_counted = 0;
	int unsigned       burst_left    = 0;
	bit                gaps_on       = 1'b1;
	bit                sink_hold_req = 1'b0;

	function automatic void paint_attr(int unsigned idx, logic [ATTR_W-1:0] a);
		if (idx < CELL_TOTAL) begin
			screen_mirror[idx][15:8] = a;
		end
	endfunction

	function automatic void paint_char(int unsigned idx, logic [CHAR_W-1:0] c);
		if (idx < CELL_TOTAL) begin
			screen_mirror[idx][7:0] = c;
		end
	endfunction

	function automatic void hide_cursor();
		paint_attr(cursor_pos, text_attr_m);
	endfunction

	function automatic void show_cursor();
		if (cursor_on_m) begin
			paint_attr(cursor_pos, cursor_attr_m);
		end
	endfunction

	// Shift every row up by one and blank the new bottom row
	function automatic void scroll_screen();
		for (int unsigned i = 0; i + SCREEN_COLS < CELL_TOTAL; i++) begin
			screen_mirror[i] = screen_mirror[i + SCREEN_COLS];
		end
		for (int unsigned i = CELL_TOTAL - SCREEN_COLS; i < CELL_TOTAL; i++) begin
			screen_mirror[i] = {text_attr_m, CH_BLANK};
		end
		sweep_count++;
	endfunction

	function automatic void place_cursor(int unsigned c, int unsigned r);
		hide_cursor();
		cursor_pos = r * SCREEN_COLS + c;
		show_cursor();
	endfunction

	// Advance the mirror by one transaction and return the result it owes
	function automatic console_result_t console_advance(kind_t k, logic [CHAR_W-1:0] ch,
			logic [COL_W-1:0] col_in, logic [ROW_W-1:0] row_in);
		int unsigned     c;
		int unsigned     r;
		int unsigned     idx;
		console_result_t res;
		c   = (col_in > SCREEN_COLS - 1) ? SCREEN_COLS - 1 : col_in;
		r   = (row_in > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : row_in;
		res = '0;
		case (k)
			KIND_PUT: begin
				if (ch == CH_NEWLINE) begin
					if (cursor_pos / SCREEN_COLS >= SCREEN_ROWS - 1) begin
						hide_cursor();
						scroll_screen();
						place_cursor(0, SCREEN_ROWS - 1);
					end else begin
						place_cursor(0, cursor_pos / SCREEN_COLS + 1);
					end
				end else if (ch == CH_BACKSPACE) begin
					if (cursor_pos != 0) begin
						hide_cursor();
						cursor_pos--;
						paint_char(cursor_pos, CH_BLANK);
						show_cursor();
					end
				end else if (ch != CH_NUL) begin
					hide_cursor();
					paint_char(cursor_pos, ch);
					if (cursor_pos >= CELL_TOTAL - 1) begin
						scroll_screen();
						cursor_pos = CELL_TOTAL - SCREEN_COLS;
					end else begin
						cursor_pos++;
					end
					show_cursor();
				end
			end
			KIND_SETPOS: place_cursor(c, r);
			KIND_CLEAR: begin
				hide_cursor();
				for (int unsigned i = 0; i < CELL_TOTAL; i++) begin
					screen_mirror[i] = {text_attr_m, CH_BLANK};
				end
				cursor_pos = 0;
				show_cursor();
				sweep_count++;
			end
			default: begin
				idx      = r * SCREEN_COLS + c;
				res.ch   = screen_mirror[idx][7:0];
				res.attr = screen_mirror[idx][15:8];
			end
		endcase
		res.col = COL_W'(cursor_pos % SCREEN_COLS);
		res.row = ROW_W'(cursor_pos / SCREEN_COLS);
		return res;
	endfunction

	// True when the transaction would make the block sweep the whole screen
	function automatic bit sweeps_screen(kind_t k, logic [CHAR_W-1:0] ch);
		if (k == KIND_CLEAR) begin
			return 1'b1;
		end
		if (k != KIND_PUT || ch == CH_NUL || ch == CH_BACKSPACE) begin
			return 1'b0;
		end
		if (ch == CH_NEWLINE) begin
			return cursor_pos / SCREEN_COLS >= SCREEN_ROWS - 1;
		end
		return cursor_pos >= CELL_TOTAL - 1;
	endfunction

	function automatic logic [CHAR_W-1:0] pick_printable();
		logic [CHAR_W-1:0] v;
		do begin
			v = CHAR_W'($urandom_range(1, 255));
		end while (v == CH_NEWLINE || v == CH_BACKSPACE);
		return v;
	endfunction

	// Mostly printable text, with newlines, backspaces and the odd NUL
	function automatic logic [CHAR_W-1:0] pick_text_char();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll < 2) begin
			return CH_NEWLINE;
		end
		if (roll < 4) begin
			return CH_BACKSPACE;
		end
		if (roll == 4) begin
			return CH_NUL;
		end
		return pick_printable();
	endfunction

	task automatic report_error(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// Sender: offer one transaction, hold it until the handshake, then
	// record what the block owes. Gaps come between random-length bursts.
	// ------------------------------------------------------------------
	task automatic send_item(input kind_t k, input logic [CHAR_W-1:0] ch,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
		int unsigned gap;
		// Stay within the sweep budget: move the cursor instead
		if (sweeps_screen(k, ch) && sweep_count >= SWEEP_BUDGET) begin
			k   = KIND_SETPOS;
			row = ROW_W'($urandom_range(0, SCREEN_ROWS - 2));
		end
		if (gaps_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left != 0) begin
			burst_left--;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= {3'b000, row, col, ch};
		do begin
			@(posedge clk);
		end while (s_axis_tready !== 1'b1);
		pending_results.push_back(console_advance(k, ch, col, row));
		if (!(k == KIND_PUT && ch == CH_NUL)) begin
			items_counted++;
		end
	endtask

	// Drop valid and wait until every result is back and the block is quiet
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_TEXT_ATTR:   text_attr_m   = value;
			REG_CURSOR_ATTR: cursor_attr_m = value;
			REG_CURSOR_ON:   cursor_on_m   = value[0];
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [COL_W-1:0] col_near_cursor();
		int unsigned c;
		c = cursor_pos % SCREEN_COLS;
		c = (c > 6) ? c - $urandom_range(0, 6) : 0;
		return COL_W'(c);
	endfunction

	// ------------------------------------------------------------------
	// Result sink: a changing stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned span;
		int unsigned mode;
		int unsigned hold_left;
		int unsigned phase;
		span      = 0;
		mode      = 0;
		hold_left = 0;
		phase     = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left     = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				if (span == 0) begin
					span = $urandom_range(16, 200);
					mode = $urandom_range(0, 3);
				end
				span--;
				case (mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= 1'($urandom_range(0, 1));
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (phase % 8 > 2);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker: compare each accepted transaction with the oldest
	// prediction, field by field
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		console_result_t got;
		console_result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = console_result_t'(m_axis_tdata[28:0]);
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %h arrived with none outstanding",
					m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.col !== want.col)
					report_error($sformatf("cursor_col got %0d expected %0d",
						got.col, want.col));
				if (got.row !== want.row)
					report_error($sformatf("cursor_row got %0d expected %0d",
						got.row, want.row));
				if (got.ch !== want.ch)
					report_error($sformatf("cell_char got %h expected %h",
						got.ch, want.ch));
				if (got.attr !== want.attr)
					report_error($sformatf("cell_attr got %h expected %h",
						got.attr, want.attr));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** text_console_writer_unit: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Edge cases: clear before any read, saturated positions, NUL, backspace
	// at the first cell, printing into the last cell and newline on the last row
	task automatic test_directed_edges();
		send_item(KIND_PUT,    8'h78,        7'd0,   6'd0);   // before the first clear
		send_item(KIND_CLEAR,  8'hFF,        7'd127, 6'd63);
		send_item(KIND_READ,   8'h00,        7'd0,   6'd0);   // cursor cell
		send_item(KIND_READ,   8'h00,        7'd127, 6'd63);  // saturates to the last cell
		send_item(KIND_PUT,    8'h41,        7'd0,   6'd0);
		send_item(KIND_PUT,    CH_NUL,       7'd0,   6'd0);
		send_item(KIND_PUT,    8'hFF,        7'd0,   6'd0);
		send_item(KIND_PUT,    8'h01,        7'd0,   6'd0);
		send_item(KIND_READ,   8'h00,        7'd1,   6'd0);
		send_item(KIND_PUT,    CH_BACKSPACE, 7'd0,   6'd0);
		send_item(KIND_PUT,    CH_BACKSPACE, 7'd0,   6'd0);
		send_item(KIND_PUT,    CH_BACKSPACE, 7'd0,   6'd0);
		send_item(KIND_PUT,    CH_BACKSPACE, 7'd0,   6'd0);   // already at the first cell
		send_item(KIND_READ,   8'h00,        7'd1,   6'd0);
		send_item(KIND_SETPOS, 8'h00,        7'd127, 6'd63);  // saturates to (79,49)
		send_item(KIND_PUT,    8'h5A,        7'd0,   6'd0);   // last cell: scroll
		send_item(KIND_READ,   8'h00,        7'd79,  6'd48);
		send_item(KIND_SETPOS, 8'h00,        7'd10,  6'd49);
		send_item(KIND_PUT,    CH_NEWLINE,   7'd0,   6'd0);   // last row: scroll
		send_item(KIND_READ,   8'h00,        7'd79,  6'd47);
		send_item(KIND_SETPOS, 8'h00,        7'd79,  6'd20);
		send_item(KIND_PUT,    CH_NEWLINE,   7'd0,   6'd0);
		send_item(KIND_READ,   8'h00,        7'd79,  6'd20);
		send_item(KIND_READ,   8'h00,        7'd0,   6'd21);
	endtask

	// Register extremes, an invisible cursor and a write to the spare slot
	task automatic test_register_settings();
		drain_results();
		write_register(REG_TEXT_ATTR,   8'hFF);
		write_register(REG_CURSOR_ATTR, 8'h00);
		write_register(REG_CURSOR_ON,   8'hFE);
		write_register(REG_SPARE,       8'h5A);
		send_item(KIND_SETPOS, 8'h00,      7'd3, 6'd3);
		send_item(KIND_PUT,    8'h30,      7'd0, 6'd0);
		send_item(KIND_READ,   8'h00,      7'd3, 6'd3);
		send_item(KIND_READ,   8'h00,      7'd4, 6'd3);
		send_item(KIND_PUT,    CH_NEWLINE, 7'd0, 6'd0);
		send_item(KIND_READ,   8'h00,      7'd0, 6'd4);
		drain_results();
		write_register(REG_TEXT_ATTR,   8'h00);
		write_register(REG_CURSOR_ATTR, 8'hFF);
		write_register(REG_CURSOR_ON,   8'h01);
		send_item(KIND_SETPOS, 8'h00, 7'd0,  6'd10);
		send_item(KIND_PUT,    8'h7E, 7'd0,  6'd0);
		send_item(KIND_READ,   8'h00, 7'd0,  6'd10);
		send_item(KIND_READ,   8'h00, 7'd1,  6'd10);
		send_item(KIND_CLEAR,  8'h00, 7'd0,  6'd0);
		send_item(KIND_READ,   8'h00, 7'd0,  6'd0);
		send_item(KIND_READ,   8'h00, 7'd40, 6'd25);
		drain_results();
		write_register(REG_TEXT_ATTR,   TEXT_ATTR_RST);
		write_register(REG_CURSOR_ATTR, CURSOR_ATTR_RST);
		write_register(REG_CURSOR_ON,   8'h01);
	endtask

	// Hold the sink off for a long stretch while text keeps coming, so the
	// block fills up and stalls its input
	task automatic test_output_backpressure();
		gaps_on       = 1'b0;
		sink_hold_req = 1'b1;
		for (int unsigned i = 0; i < 48; i++) begin
			if (i % 3 == 2) begin
				send_item(KIND_READ, 8'h00, col_near_cursor(),
					ROW_W'(cursor_pos / SCREEN_COLS));
			end else begin
				send_item(KIND_PUT, pick_printable(), 7'd0, 6'd0);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Mostly text runs and read-backs with random content, plus register
	// changes, clears, backspace runs and raw noise
	task automatic test_random_traffic();
		int unsigned       n;
		int unsigned       roll;
		logic [COL_W-1:0]  c;
		logic [ROW_W-1:0]  r;
		logic [CHAR_W-1:0] v;
		items_counted = 0;
		while (items_counted < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll < 10) begin
				// text run from a fresh position, sometimes near the bottom
				if ($urandom_range(0, 4) == 0) begin
					r = ROW_W'($urandom_range(46, 63));
					c = COL_W'($urandom_range(60, 127));
				end else begin
					r = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
					c = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(0, 127))
						: COL_W'($urandom_range(0, SCREEN_COLS - 1));
				end
				send_item(KIND_SETPOS, CHAR_W'($urandom_range(0, 255)), c, r);
				n = $urandom_range(3, 24);
				repeat (n) send_item(KIND_PUT, pick_text_char(),
					COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)));
			end else if (roll < 14) begin
				// read back around the cursor or anywhere
				n = $urandom_range(2, 8);
				repeat (n) begin
					if ($urandom_range(0, 1) == 0) begin
						c = col_near_cursor();
						r = ROW_W'(cursor_pos / SCREEN_COLS);
					end else begin
						c = COL_W'($urandom_range(0, 127));
						r = ROW_W'($urandom_range(0, 63));
					end
					send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), c, r);
				end
			end else if (roll < 17) begin
				// noise: any kind, any field value
				n = $urandom_range(1, 6);
				repeat (n) send_item(kind_t'($urandom_range(0, 3)),
					CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
					ROW_W'($urandom_range(0, 63)));
			end else if (roll == 17) begin
				// register change between phases
				drain_results();
				n = $urandom_range(1, 3);
				repeat (n) begin
					case ($urandom_range(0, 3))
						0:       v = 8'h00;
						1:       v = 8'hFF;
						default: v = CHAR_W'($urandom_range(0, 255));
					endcase
					write_register(CFG_INDEX_W'($urandom_range(0, 3)), v);
				end
			end else if (roll == 18) begin
				send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
					COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 63)));
			end else begin
				// backspace run, then look at what it left
				n = $urandom_range(1, 10);
				repeat (n) send_item(KIND_PUT, CH_BACKSPACE, 7'd0, 6'd0);
				send_item(KIND_READ, 8'h00, col_near_cursor(),
					ROW_W'(cursor_pos / SCREEN_COLS));
			end
		end
	endtask

	initial begin
		// Screen contents are undefined until the first clear; the mirror
		// starts at zero and is never read before that clear
		for (int unsigned i = 0; i < CELL_TOTAL; i++) begin
			screen_mirror[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_register_settings();
		test_output_backpressure();
		test_random_traffic();

		drain_results();
		if (fail_count == 0) begin
			$display("** text_console_writer_unit: PASSED **");
		end else begin
			$display("** text_console_writer_unit: FAILED **");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/text_console_writer_unit.sv
test/tb_text_console_writer_unit.sv
